// ===== rtl/core/mbsa_pkg.sv =====
// Shared types, constants and helpers of the MIDI byte stream message assembler.
// Used by the parser, the result queue and the top level; depends on nothing.
package mbsa_pkg;

  localparam logic [7:0] SOX = 8'hF0;
  localparam logic [7:0] EOX = 8'hF7;
  localparam logic [7:0] RT_UNDEF_A = 8'hF9;
  localparam logic [7:0] RT_UNDEF_B = 8'hFD;

  // data byte count code for an undefined status byte
  localparam logic [1:0] DC_UNDEF = 2'd3;

  // default depth of the result queue
  localparam int unsigned OUT_DEPTH_DEF = 4;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] data_one;
    logic       data_one_valid;
    logic [6:0] data_two;
    logic       data_two_valid;
    logic       last;
  } msg_t;

  // up to two results of one parsed byte, in emit order
  typedef struct packed {
    logic [1:0] n;
    msg_t       r0;
    msg_t       r1;
  } step_t;

  function automatic logic [1:0] data_count(input logic [7:0] s);
    logic [1:0] c;
    c = DC_UNDEF;
    if (s < 8'hC0) begin
      c = 2'd2;
    end else if (s < 8'hE0) begin
      c = 2'd1;
    end else if (s < 8'hF0) begin
      c = 2'd2;
    end else begin
      case (s)
        8'hF1:   c = 2'd1;
        8'hF2:   c = 2'd2;
        8'hF3:   c = 2'd1;
        8'hF6:   c = 2'd0;
        default: c = DC_UNDEF;
      endcase
    end
    return c;
  endfunction

  // absent data fields read as zero
  function automatic msg_t make_msg(input logic [7:0] st, input logic [6:0] d1,
                                    input logic v1, input logic [6:0] d2,
                                    input logic v2);
    msg_t m;
    m.status         = st;
    m.data_one       = v1 ? d1 : 7'd0;
    m.data_one_valid = v1;
    m.data_two       = v2 ? d2 : 7'd0;
    m.data_two_valid = v2;
    m.last           = 1'b0;
    return m;
  endfunction

endpackage

// ===== rtl/core/mbsa_parser.sv =====
// Parser state and per-byte decode of the MIDI message assembler.
// Depends on mbsa_pkg; produces up to two results per parsed byte.
module mbsa_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      byte_i,
  output mbsa_pkg::step_t step_o
);
  import mbsa_pkg::*;

  logic       synced_q, synced_d;
  logic       cur_v_q, cur_v_d;
  logic [7:0] cur_s_q, cur_s_d;
  logic       run_v_q, run_v_d;
  logic [7:0] run_s_q, run_s_d;
  logic [1:0] need_q, need_d;
  logic [1:0] got_q, got_d;
  logic [6:0] held_q [2];
  logic [6:0] held_d [2];

  logic       emit_a, emit_b;
  msg_t       msg_a, msg_b;
  logic       go;
  logic       chk;
  logic [1:0] cnt;

  always_comb begin
    synced_d  = synced_q;
    cur_v_d   = cur_v_q;
    cur_s_d   = cur_s_q;
    run_v_d   = run_v_q;
    run_s_d   = run_s_q;
    need_d    = need_q;
    got_d     = got_q;
    held_d[0] = held_q[0];
    held_d[1] = held_q[1];
    emit_a    = 1'b0;
    emit_b    = 1'b0;
    msg_a     = make_msg(byte_i, 7'd0, 1'b0, 7'd0, 1'b0);
    msg_b     = make_msg(byte_i, 7'd0, 1'b0, 7'd0, 1'b0);
    go        = 1'b0;
    chk       = 1'b0;
    cnt       = 2'd0;

    if (byte_i >= 8'hF8) begin
      // real-time: pass through unless undefined
      emit_a = (byte_i != RT_UNDEF_A) && (byte_i != RT_UNDEF_B);
    end else begin
      go = 1'b1;
      if (!synced_q) begin
        if (!byte_i[7] || byte_i == EOX) begin
          go = 1'b0;
        end else begin
          synced_d = 1'b1;
        end
      end

      // inside a SysEx
      if (go && cur_v_q && cur_s_q == SOX) begin
        emit_a = 1'b1;
        if (!byte_i[7]) begin
          msg_a = make_msg(SOX, byte_i[6:0], 1'b1, 7'd0, 1'b0);
          go    = 1'b0;
        end else begin
          msg_a   = make_msg(EOX, 7'd0, 1'b0, 7'd0, 1'b0);
          cur_v_d = 1'b0;
          run_v_d = 1'b0;
          if (byte_i == EOX) begin
            go = 1'b0;
          end
        end
      end

      if (go) begin
        if (byte_i[7]) begin
          if (cur_v_d) begin
            // status in mid-message: drop it and lose sync
            synced_d = 1'b0;
            cur_v_d  = 1'b0;
            run_v_d  = 1'b0;
          end else begin
            cur_s_d = byte_i;
            cur_v_d = 1'b1;
            if (byte_i == SOX) begin
              emit_b = 1'b1;
              msg_b  = make_msg(SOX, 7'd0, 1'b0, 7'd0, 1'b0);
            end else begin
              cnt = data_count(byte_i);
              if (cnt == DC_UNDEF) begin
                synced_d = 1'b0;
                cur_v_d  = 1'b0;
                run_v_d  = 1'b0;
              end else begin
                need_d = cnt;
                got_d  = 2'd0;
                chk    = 1'b1;
              end
            end
          end
        end else begin
          chk = 1'b1;
          if (!cur_v_d) begin
            if (!run_v_d) begin
              // orphan data byte
              synced_d = 1'b0;
              cur_v_d  = 1'b0;
              run_v_d  = 1'b0;
              chk      = 1'b0;
            end else begin
              cur_s_d = run_s_q;
              cur_v_d = 1'b1;
              need_d  = data_count(run_s_q);
              got_d   = 2'd0;
            end
          end
          if (chk && !got_d[1]) begin
            held_d[got_d[0]] = byte_i[6:0];
            got_d            = got_d + 2'd1;
          end
        end

        if (chk && got_d == need_d) begin
          emit_b = 1'b1;
          msg_b  = make_msg(cur_s_d, held_d[0], need_d != 2'd0, held_d[1],
                            need_d[1]);
          if (cur_s_d >= 8'h80 && cur_s_d < 8'hF0) begin
            run_s_d = cur_s_d;
            run_v_d = 1'b1;
          end else begin
            run_v_d = 1'b0;
          end
          cur_v_d = 1'b0;
        end
      end
    end
  end

  // pack results in order, mark the final one
  always_comb begin
    step_o.n  = 2'd0;
    step_o.r0 = msg_a;
    step_o.r1 = msg_b;
    if (fire_i) begin
      step_o.n = {1'b0, emit_a} + {1'b0, emit_b};
    end
    if (!emit_a) begin
      step_o.r0 = msg_b;
    end
    step_o.r0.last = !(emit_a && emit_b);
    step_o.r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      synced_q <= 1'b0;
      cur_v_q  <= 1'b0;
      cur_s_q  <= 8'd0;
      run_v_q  <= 1'b0;
      run_s_q  <= 8'd0;
      need_q   <= 2'd0;
      got_q    <= 2'd0;
    end else if (fire_i) begin
      synced_q <= synced_d;
      cur_v_q  <= cur_v_d;
      cur_s_q  <= cur_s_d;
      run_v_q  <= run_v_d;
      run_s_q  <= run_s_d;
      need_q   <= need_d;
      got_q    <= got_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      held_q[0] <= held_d[0];
      held_q[1] <= held_d[1];
    end
  end

  a_sysex_synced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_v_q && cur_s_q == SOX) |-> synced_q)
    else $error("SysEx in progress while unsynchronized");

  a_run_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_v_q |-> (run_s_q >= 8'h80 && run_s_q < 8'hF0))
    else $error("running status is not a channel status");

  a_run_needs_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_v_q || cur_v_q) |-> synced_q)
    else $error("message state held while unsynchronized");

endmodule

// ===== rtl/core/mbsa_out_fifo.sv =====
// Result queue of the MIDI message assembler: takes up to two results a cycle,
// hands out one. Depends on mbsa_pkg for the result types.
module mbsa_out_fifo #(
  parameter int unsigned Depth = mbsa_pkg::OUT_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mbsa_pkg::step_t push_i,
  output logic            room_o,
  output mbsa_pkg::msg_t  head_o,
  output logic            head_valid_o,
  input  logic            pop_i
);
  import mbsa_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  msg_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, wr_nx;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_nx        = wrap_inc(wr_q);
  assign pop          = pop_i && (count_q != '0);
  assign room_o       = count_q <= CntW'(Depth - 2);
  assign head_valid_o = count_q != '0;
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d    = wr_q;
    rd_d    = pop ? wrap_inc(rd_q) : rd_q;
    count_d = count_q + CntW'(push_i.n) - CntW'(pop);
    if (push_i.n == 2'd1) begin
      wr_d = wr_nx;
    end else if (push_i.n == 2'd2) begin
      wr_d = wrap_inc(wr_nx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_nx] <= push_i.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> room_o)
    else $error("push into a queue without room");

  a_double_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n == 2'd2 && !pop) |=> count_q == $past(count_q) + CntW'(2))
    else $error("double push not counted");

endmodule

// ===== rtl/core/midi_byte_stream_message_assembler_top.sv =====
// Top level of the MIDI byte stream message assembler.
// Depends on mbsa_pkg, mbsa_parser and mbsa_out_fifo.
//
// Usage:
//   Input channel: one received MIDI byte per transfer on rx_byte_i, moved when
//   in_valid_i is high and in_stall_o is low. Output channel: one assembled
//   message per transfer on the msg_*_o ports, moved when out_valid_o is high
//   and out_stall_i is low. msg_last_o marks the final result of one byte.
//   A taken byte lands in the input register, is parsed from there once the
//   result queue has room, and its results are registered into that queue.
//   Throughput: one byte per cycle while not stalled. A byte gives zero, one
//   or two results; a SysEx closed by a status byte can give two, and those
//   leave one per cycle, so sustained input follows the output drain rate.
//   The input register stalls only when the result queue (OutDepth entries)
//   cannot take two more results; a stalled receiver fills the queue first.
//   Reset: parser returns to unsynchronized with no message and no running
//   status; the input register and the result queue are emptied.
module midi_byte_stream_message_assembler_top #(
  parameter int unsigned OutDepth = mbsa_pkg::OUT_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] msg_status_o,
  output logic [6:0] msg_data_one_o,
  output logic       msg_data_one_valid_o,
  output logic [6:0] msg_data_two_o,
  output logic       msg_data_two_valid_o,
  output logic       msg_last_o
);
  import mbsa_pkg::*;

  // input register
  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       room;
  logic       fire;
  step_t      step;
  msg_t       head;

  // parse the held byte whenever the queue can take both possible results
  assign fire       = vld_q && room;
  assign in_stall_o = vld_q && !room;
  // when not stalled the held byte is consumed, so reload from the input
  assign vld_d      = in_stall_o ? vld_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  mbsa_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (byte_q),
    .step_o (step)
  );

  mbsa_out_fifo #(
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (step),
    .room_o       (room),
    .head_o       (head),
    .head_valid_o (out_valid_o),
    .pop_i        (!out_stall_i)
  );

  assign msg_status_o         = head.status;
  assign msg_data_one_o       = head.data_one;
  assign msg_data_one_valid_o = head.data_one_valid;
  assign msg_data_two_o       = head.data_two;
  assign msg_data_two_valid_o = head.data_two_valid;
  assign msg_last_o           = head.last;

  a_stall_means_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> vld_q)
    else $error("stall without a held byte");

  a_fire_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !in_valid_i) |=> !vld_q)
    else $error("parsed byte not released");

  a_stalled_byte_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(byte_q))
    else $error("held byte changed while stalled");

endmodule
